// ===== hdl/text_terminal_cursor_scroll_macros.svh =====
// assertion macros for the text terminal block
// used by the top level; expects clk_i and rst_ni in the calling scope
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_MACROS_SVH

// same-cycle implication, disabled during reset
`define TTCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TTCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ttcs_pkg.sv =====
// shared types and constants for the text terminal block
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package ttcs_pkg;

  // default screen geometry
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // field widths
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CELL_W      = 16;
  localparam int unsigned ROW_FIELD_W = 5;
  localparam int unsigned COL_FIELD_W = 7;

  // character codes and cell values
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CHAR};
  localparam logic [CELL_W-1:0] BLANK_CELL   = '0;

  // item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [CHAR_W-1:0]      character;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]      cell_data;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic                   scrolled;
  } out_item_t;

endpackage

// ===== hdl/ttcs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ttcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/text_terminal_cursor_scroll.sv =====
// text terminal top level: cursor control, screen ram sequencing, result register
// depends on ttcs_pkg, ttcs_ram and text_terminal_cursor_scroll_macros.svh
`timescale 1ns / 1ps
`include "text_terminal_cursor_scroll_macros.svh"

// Character-cell text terminal. The screen lives in one ROWS x COLUMNS ram of
// 16-bit cells (character low byte, attribute high byte) addressed as a ring
// of rows, so a scroll only moves a top-row pointer and blanks one row.
// After reset a clearing pass writes space/0x07 to every cell, one cell a
// cycle; no item is accepted until it ends, while attribute writes are taken
// at any time. Items are taken one at a time: a put finishes in the cycle it
// is taken, a read waits in ST_RDATA for the registered ram data, and a put
// that scrolls waits in ST_SCROLL while the single ram write port blanks the
// new bottom row. A finished result waits in an output register, so the next
// item can be taken meanwhile; if it is full, the result parks and intake stops.
module text_terminal_cursor_scroll #(
  parameter int unsigned COLUMNS = ttcs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = ttcs_pkg::ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ttcs_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ttcs_pkg::out_item_t   out_item_o
);

  import ttcs_pkg::*;

  localparam int unsigned DEPTH  = ROWS * COLUMNS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDATA,
    ST_SCROLL,
    ST_HOLD
  } state_e;

  state_e            state_q, state_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  top_q, top_d;
  logic [ROW_W-1:0]  clr_row_q, clr_row_d;
  logic [COL_W-1:0]  clr_col_q, clr_col_d;
  logic [CHAR_W-1:0] attr_q;
  out_item_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic              accept, slot_free, wrap, scroll, fin, rd_in_range;
  out_item_t         fin_item;

  // logical row to physical ram row through the ring offset
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, top};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  // physical row and column to ram address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign rd_in_range = ({1'b0, in_item_i.read_row} < (ROW_FIELD_W+1)'(ROWS)) &&
                       ({1'b0, in_item_i.read_column} < (COL_FIELD_W+1)'(COLUMNS));

  // sequencer: clearing pass, put and read handling, scroll blanking, result parking
  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    top_d       = top_q;
    clr_row_d   = clr_row_q;
    clr_col_d   = clr_col_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    wrap        = 1'b0;
    scroll      = 1'b0;
    fin         = 1'b0;
    fin_item    = '0;

    // output register drains when taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(clr_row_q, clr_col_q);
        ram_wdata = RESET_CELL;
        if (clr_col_q == LAST_COL) begin
          clr_col_d = '0;
          if (clr_row_q == LAST_ROW) begin
            clr_row_d = '0;
            state_d   = ST_IDLE;
          end else begin
            clr_row_d = clr_row_q + 1'b1;
          end
        end else begin
          clr_col_d = clr_col_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.kind == KIND_READ) begin
            if (rd_in_range) begin
              ram_re    = 1'b1;
              ram_raddr = cell_addr(phys_row(in_item_i.read_row[ROW_W-1:0], top_q),
                                    in_item_i.read_column[COL_W-1:0]);
              state_d   = ST_RDATA;
            end else begin
              fin                    = 1'b1;
              fin_item.cursor_row    = ROW_FIELD_W'(cur_row_q);
              fin_item.cursor_column = COL_FIELD_W'(cur_col_q);
            end
          end else begin
            // store the character, or treat newline as a line break only
            if (in_item_i.character != NEWLINE_CHAR) begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr(phys_row(cur_row_q, top_q), cur_col_q);
              ram_wdata = {attr_q, in_item_i.character};
              if (cur_col_q == LAST_COL) begin
                wrap = 1'b1;
              end else begin
                cur_col_d = cur_col_q + 1'b1;
              end
            end else begin
              wrap = 1'b1;
            end
            if (wrap) begin
              cur_col_d = '0;
              if (cur_row_q == LAST_ROW) begin
                // old top row becomes the new bottom row
                scroll    = 1'b1;
                clr_row_d = top_q;
                clr_col_d = '0;
                top_d     = (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
                state_d   = ST_SCROLL;
              end else begin
                cur_row_d = cur_row_q + 1'b1;
              end
            end
            if (!scroll) begin
              fin                    = 1'b1;
              fin_item.cursor_row    = ROW_FIELD_W'(cur_row_d);
              fin_item.cursor_column = COL_FIELD_W'(cur_col_d);
            end
          end
        end
      end
      ST_RDATA: begin
        fin                    = 1'b1;
        fin_item.cell_data     = ram_rdata;
        fin_item.cursor_row    = ROW_FIELD_W'(cur_row_q);
        fin_item.cursor_column = COL_FIELD_W'(cur_col_q);
      end
      ST_SCROLL: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(clr_row_q, clr_col_q);
        ram_wdata = BLANK_CELL;
        if (clr_col_q == LAST_COL) begin
          clr_col_d              = '0;
          fin                    = 1'b1;
          fin_item.cursor_row    = ROW_FIELD_W'(cur_row_q);
          fin_item.cursor_column = COL_FIELD_W'(cur_col_q);
          fin_item.scrolled      = 1'b1;
        end else begin
          clr_col_d = clr_col_q + 1'b1;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // hand a finished item to the output register, or park it
    if (fin) begin
      if (slot_free) begin
        out_valid_d = 1'b1;
        out_item_d  = fin_item;
        state_d     = ST_IDLE;
      end else begin
        res_d   = fin_item;
        state_d = ST_HOLD;
      end
    end
  end

  // state, cursor, ring pointer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      top_q       <= '0;
      clr_row_q   <= '0;
      clr_col_q   <= '0;
      attr_q      <= RESET_ATTR;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      top_q       <= top_d;
      clr_row_q   <= clr_row_d;
      clr_col_q   <= clr_col_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  // screen store
  ttcs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // checks
  `TTCS_ASSERT_IMP(a_busy_no_accept, (state_q == ST_CLEAR) || (state_q == ST_SCROLL), !in_ready_o, "item taken while sweeping the store")
  `TTCS_ASSERT_IMP(a_scroll_cursor, out_valid_o && out_item_o.scrolled, (out_item_o.cursor_row == ROW_FIELD_W'(ROWS - 1)) && (out_item_o.cursor_column == '0), "scrolled item without cursor at bottom left")
  `TTCS_ASSERT_IMP(a_no_rw_overlap, ram_we, !ram_re, "ram read and write in the same cycle")
  `TTCS_ASSERT_IMP(a_rows_in_range, 1'b1, (top_q <= LAST_ROW) && (cur_row_q <= LAST_ROW), "row pointer beyond the screen")
  `TTCS_ASSERT_NXT(a_read_latency, accept && (in_item_i.kind == KIND_READ) && rd_in_range, state_q == ST_RDATA, "read item did not wait for ram data")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the text terminal block: cursor, wrap, scroll and cell reads
// depends on ttcs_pkg and the text_terminal_cursor_scroll top level
`timescale 1ns / 1ps

module testbench;
  import ttcs_pkg::*;

  localparam int unsigned COLUMNS     = COLUMNS_DEF;
  localparam int unsigned ROWS        = ROWS_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // block inputs, all at known values from time zero
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // screen and cursor as the block should hold them
  logic [CELL_W-1:0] screen_model [ROWS*COLUMNS];
  int unsigned       cursor_row_model;
  int unsigned       cursor_col_model;
  logic [7:0]        attr_model;

  out_item_t   predicted_results [$];
  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          idle_on;
  int unsigned stall_request;
  int unsigned stall_left;

  text_terminal_cursor_scroll dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("text_terminal_cursor_scroll test failed");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // cursor to the start of the next row, scrolling at the bottom
  function automatic bit advance_row();
    cursor_col_model = 0;
    cursor_row_model++;
    if (cursor_row_model >= ROWS) begin
      for (int unsigned i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
        screen_model[i] = screen_model[i + COLUMNS];
      end
      for (int unsigned i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++) begin
        screen_model[i] = BLANK_CELL;
      end
      cursor_row_model = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected result of one item, updating the screen and cursor
  function automatic out_item_t predict_terminal(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.kind == KIND_READ) begin
      if (it.read_row < ROWS && it.read_column < COLUMNS) begin
        r.cell_data = screen_model[it.read_row * COLUMNS + it.read_column];
      end
    end else if (it.character == NEWLINE_CHAR) begin
      r.scrolled = advance_row();
    end else begin
      screen_model[cursor_row_model * COLUMNS + cursor_col_model] = {attr_model, it.character};
      cursor_col_model++;
      if (cursor_col_model >= COLUMNS) begin
        r.scrolled = advance_row();
      end
    end
    r.cursor_row    = ROW_FIELD_W'(cursor_row_model);
    r.cursor_column = COL_FIELD_W'(cursor_col_model);
    return r;
  endfunction

  function automatic in_item_t put_item(logic [7:0] ch);
    in_item_t it;
    it             = in_item_t'($urandom);
    it.kind        = KIND_PUT;
    it.character   = ch;
    return it;
  endfunction

  function automatic in_item_t read_item(int unsigned row, int unsigned col);
    in_item_t it;
    it             = in_item_t'($urandom);
    it.kind        = KIND_READ;
    it.read_row    = ROW_FIELD_W'(row);
    it.read_column = COL_FIELD_W'(col);
    return it;
  endfunction

  // read target: cursor row, bottom row, anywhere on screen, or anywhere in field range
  function automatic in_item_t random_read();
    int unsigned pick, row, col;
    pick = $urandom_range(0, 99);
    col  = $urandom_range(0, COLUMNS - 1);
    if (pick < 30) row = cursor_row_model;
    else if (pick < 45) row = ROWS - 1;
    else if (pick < 90) row = $urandom_range(0, ROWS - 1);
    else begin
      row = $urandom_range(0, 31);
      col = $urandom_range(0, 127);
    end
    return read_item(row, col);
  endfunction

  function automatic logic [7:0] printable_char();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    while (ch == NEWLINE_CHAR) ch = 8'($urandom_range(0, 255));
    return ch;
  endfunction

  // offer one item, hold it until taken, then maybe idle
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
    predicted_results.push_back(predict_terminal(it));
    items_sent++;
    gap = idle_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // lower valid and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_attribute(input logic [7:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    attr_model   = value;
  endtask

  // one line of text with reads mixed in, mostly ended by a newline
  task automatic send_line();
    int unsigned pick, len;
    pick = $urandom_range(0, 99);
    if (pick < 60) len = $urandom_range(0, 20);
    else if (pick < 80) len = $urandom_range(21, 60);
    else if (pick < 90) len = $urandom_range(COLUMNS - 2, COLUMNS + 2);
    else len = COLUMNS;
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(0, 4) == 0) send_item(random_read());
      send_item(put_item(printable_char()));
    end
    if ($urandom_range(0, 9) < 8) send_item(put_item(NEWLINE_CHAR));
  endtask

  // fully random items
  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(1, 8);
    repeat (len) send_item(in_item_t'($urandom));
  endtask

  task automatic test_reset_contents();
    idle_on = 1'b0;
    send_item(read_item(0, 0));
    send_item(read_item(ROWS - 1, COLUMNS - 1));
    send_item(read_item(12, 40));
  endtask

  // byte extremes, newline, off-screen reads
  task automatic test_extremes();
    idle_on = 1'b1;
    send_item(put_item(8'h00));
    send_item(put_item(8'hFF));
    send_item(put_item(NEWLINE_CHAR));
    send_item(put_item(SPACE_CHAR));
    send_item(read_item(0, 0));
    send_item(read_item(0, 1));
    send_item(read_item(1, 0));
    send_item(read_item(ROWS, 0));
    send_item(read_item(0, COLUMNS));
    send_item(read_item(31, 127));
    send_item(read_item(0, 2));
  endtask

  task automatic test_attribute_extremes();
    set_attribute(8'hFF);
    send_item(put_item(8'h41));
    set_attribute(8'h00);
    send_item(put_item(8'h42));
    send_item(read_item(1, 1));
    send_item(read_item(1, 2));
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    int unsigned stop_at;
    drain_results();
    idle_on = 1'b0;
    stall_request = 400;
    stop_at = items_sent + 40;
    while (items_sent < stop_at) send_line();
  endtask

  task automatic test_random();
    logic [7:0]  attrs [9];
    int unsigned stop_at;
    attrs = '{8'h00, 8'hFF, 8'h1F, 8'hF0, RESET_ATTR, 8'h00, 8'hFF, 8'h55, 8'hAA};
    attrs[7] = 8'($urandom_range(0, 255));
    for (int unsigned p = 0; p < 9; p++) begin
      set_attribute(attrs[p]);
      idle_on = (p % 3 != 2);
      stop_at = items_sent + 185;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_line();
      end
    end
  endtask

  // receiver: forced hold-offs, random stalls, or always ready
  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left   = gap_len();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (predicted_results.size() == 0) begin
        $error("result item with none expected: %p", out_item_o);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        if (out_item_o.cell_data !== want.cell_data) begin
          $error("cell_data: expected %h, got %h", want.cell_data, out_item_o.cell_data);
          fail_count++;
        end
        if (out_item_o.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, out_item_o.cursor_row);
          fail_count++;
        end
        if (out_item_o.cursor_column !== want.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d",
                 want.cursor_column, out_item_o.cursor_column);
          fail_count++;
        end
        if (out_item_o.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0b, got %0b", want.scrolled, out_item_o.scrolled);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // screen as cleared after reset
    for (int unsigned i = 0; i < ROWS * COLUMNS; i++) screen_model[i] = RESET_CELL;
    cursor_row_model = 0;
    cursor_col_model = 0;
    attr_model       = RESET_ATTR;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_contents();
    test_extremes();
    test_attribute_extremes();
    test_backpressure();
    test_random();

    drain_results();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("text_terminal_cursor_scroll test passed");
    end else begin
      $display("text_terminal_cursor_scroll test failed");
    end
    $finish;
  end

endmodule
